// File: design/elt_pkg.sv
// Shared types and codes for the edge list table.
// Holds the beat structs of both channels and the operation and status codes.
// No dependencies.
`default_nettype none

package elt_pkg;

    localparam int VERTEX_FIELD_W = 16;
    localparam int COUNT_FIELD_W  = 11;

    typedef logic [VERTEX_FIELD_W-1:0] t_vertex;
    typedef logic [COUNT_FIELD_W-1:0]  t_count;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_QUERY  = 2'd2,
        OP_DEGREE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_INVALID   = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0] operation;
        t_vertex    vertex_a;
        t_vertex    vertex_b;
    } t_in_beat;

    typedef struct packed {
        logic [1:0] status;
        logic       found;
        t_count     degree;
        t_vertex    max_vertex;
        t_count     edge_count;
    } t_out_beat;

endpackage

`default_nettype wire

// File: design/elt_ram.sv
// Simple dual-port synchronous RAM for the edge table.
// One write port and one read port, read data registered.
// No dependencies.
`default_nettype none

module elt_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: design/edge_list_table.sv
// Edge list table: top level with the operation sequencer and the edge memory.
// Depends on elt_pkg and elt_ram.
//
// The block keeps up to MAX_EDGES (source, destination) pairs in one
// synchronous RAM, plus the edge count and the largest vertex in registers.
// It handles one item at a time. Add, any invalid request, an undirected
// out-degree and any request on an empty table go from the idle state
// straight to the done state. Remove, query and directed out-degree walk
// the table in the scan state through the single RAM read port, one
// entry per cycle; a query stops at its first match. Remove
// compacts the table in the same pass by writing each kept entry back at the
// kept position. The table needs no clearing after reset: only entries below
// the edge count are ever used. A finished result sits in an output register,
// and the block takes its next input beat while that result waits.
`default_nettype none

module edge_list_table #(
    parameter int MAX_EDGES   = 1024,
    parameter int VERTEX_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire elt_pkg::t_in_beat  i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output elt_pkg::t_out_beat      o_out_data,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_data
);

    localparam int VW = (VERTEX_BITS < elt_pkg::VERTEX_FIELD_W) ?
                        VERTEX_BITS : elt_pkg::VERTEX_FIELD_W;
    localparam int AW = $clog2(MAX_EDGES);
    localparam int CW = $clog2(MAX_EDGES + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state             r_state, n_state;
    logic               r_directed;
    logic [CW-1:0]      r_count, n_count;
    logic [VW-1:0]      r_largest, n_largest;
    elt_pkg::t_op       r_op, n_op;
    logic [VW-1:0]      r_va, n_va;
    logic [VW-1:0]      r_vb, n_vb;
    elt_pkg::t_status   r_status, n_status;
    logic               r_found, n_found;
    logic [CW-1:0]      r_deg, n_deg;
    logic [CW-1:0]      r_idx, n_idx;
    logic [CW-1:0]      r_kept, n_kept;
    logic [VW-1:0]      r_top, n_top;
    logic               r_out_valid, n_out_valid;
    elt_pkg::t_out_beat r_out, n_out;

    logic               w_in_acc;
    logic [VW-1:0]      w_in_va, w_in_vb;
    logic               w_pair_bad;
    logic               w_we;
    logic [AW-1:0]      w_waddr, w_raddr;
    logic [2*VW-1:0]    w_wdata, w_rdata;
    logic [VW-1:0]      w_s, w_t;
    logic               w_match;
    logic [CW-1:0]      w_nxt;
    logic               w_last;

    elt_ram #(
        .DEPTH (MAX_EDGES),
        .WIDTH (2 * VW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_in_va     = i_in_data.vertex_a[VW-1:0];
    assign w_in_vb     = i_in_data.vertex_b[VW-1:0];
    assign w_pair_bad  = (w_in_va == '0) || (w_in_vb == '0) ||
                         (w_in_va > r_largest) || (w_in_vb > r_largest);

    assign w_s     = w_rdata[2*VW-1:VW];
    assign w_t     = w_rdata[VW-1:0];
    assign w_match = ((w_s == r_va) && (w_t == r_vb)) ||
                     (!r_directed && (w_s == r_vb) && (w_t == r_va));
    assign w_nxt   = r_idx + 1'b1;
    assign w_last  = (w_nxt == r_count);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_largest   = r_largest;
        n_op        = r_op;
        n_va        = r_va;
        n_vb        = r_vb;
        n_status    = r_status;
        n_found     = r_found;
        n_deg       = r_deg;
        n_idx       = r_idx;
        n_kept      = r_kept;
        n_top       = r_top;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        w_we        = 1'b0;
        w_waddr     = r_kept[AW-1:0];
        w_wdata     = w_rdata;
        w_raddr     = '0;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_op     = elt_pkg::t_op'(i_in_data.operation);
                    n_va     = w_in_va;
                    n_vb     = w_in_vb;
                    n_status = elt_pkg::ST_OK;
                    n_found  = 1'b0;
                    n_deg    = '0;
                    n_idx    = '0;
                    n_kept   = '0;
                    n_top    = '0;
                    n_state  = S_DONE;
                    unique case (elt_pkg::t_op'(i_in_data.operation))
                        elt_pkg::OP_ADD: begin
                            if ((w_in_va == '0) || (w_in_vb == '0)) begin
                                n_status = elt_pkg::ST_INVALID;
                            end else if (r_count >= CW'(MAX_EDGES)) begin
                                n_status = elt_pkg::ST_FULL;
                            end else begin
                                w_we      = 1'b1;
                                w_waddr   = r_count[AW-1:0];
                                w_wdata   = {w_in_va, w_in_vb};
                                n_count   = r_count + 1'b1;
                                n_largest = r_largest;
                                if (w_in_va > n_largest) begin
                                    n_largest = w_in_va;
                                end
                                if (w_in_vb > n_largest) begin
                                    n_largest = w_in_vb;
                                end
                            end
                        end
                        elt_pkg::OP_REMOVE: begin
                            if (w_pair_bad) begin
                                n_status = elt_pkg::ST_INVALID;
                            end else if (r_count == '0) begin
                                n_status = elt_pkg::ST_NOT_FOUND;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        elt_pkg::OP_QUERY: begin
                            if (w_pair_bad) begin
                                n_status = elt_pkg::ST_INVALID;
                            end else if (r_count != '0) begin
                                n_state = S_SCAN;
                            end
                        end
                        elt_pkg::OP_DEGREE: begin
                            if (r_directed && (r_count != '0)) begin
                                n_state = S_SCAN;
                            end
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // Read one entry ahead; the data on w_rdata belongs to r_idx.
                n_idx   = w_nxt;
                w_raddr = w_nxt[AW-1:0];
                unique case (r_op)
                    elt_pkg::OP_REMOVE: begin
                        // Kept entries slide down; the write address never
                        // passes the read address, so no entry is lost.
                        if (!w_match) begin
                            w_we   = 1'b1;
                            n_kept = r_kept + 1'b1;
                            if (w_s > n_top) begin
                                n_top = w_s;
                            end
                            if (w_t > n_top) begin
                                n_top = w_t;
                            end
                        end
                        if (w_last) begin
                            n_state = S_DONE;
                            if (n_kept == r_count) begin
                                n_status = elt_pkg::ST_NOT_FOUND;
                            end else begin
                                n_count   = n_kept;
                                n_largest = n_top;
                            end
                        end
                    end
                    elt_pkg::OP_QUERY: begin
                        if (w_match) begin
                            n_found = 1'b1;
                            n_state = S_DONE;
                        end else if (w_last) begin
                            n_state = S_DONE;
                        end
                    end
                    elt_pkg::OP_DEGREE: begin
                        if (w_s == r_va) begin
                            n_deg = r_deg + 1'b1;
                        end
                        if (w_last) begin
                            n_state = S_DONE;
                        end
                    end
                    elt_pkg::OP_ADD: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out.status     = r_status;
                    n_out.found      = r_found;
                    n_out.degree     = elt_pkg::t_count'(r_deg);
                    n_out.max_vertex = elt_pkg::t_vertex'(r_largest);
                    n_out.edge_count = elt_pkg::t_count'(r_count);
                    n_out_valid      = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_directed  <= 1'b1;
            r_count     <= '0;
            r_largest   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_largest   <= n_largest;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_directed <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_va     <= n_va;
        r_vb     <= n_vb;
        r_status <= n_status;
        r_found  <= n_found;
        r_deg    <= n_deg;
        r_idx    <= n_idx;
        r_kept   <= n_kept;
        r_top    <= n_top;
        r_out    <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // The edge count never goes past the table depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_EDGES))
        else $error("edge count exceeds table depth");

    // An empty table always reports a largest vertex of zero.
    a_empty_largest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_largest == '0))
        else $error("largest vertex nonzero on empty table");

    // A walk only runs over a nonempty table, and compaction never overtakes it.
    a_scan_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> ((r_count != '0) && (r_kept <= r_idx) &&
                                 (r_idx < r_count)))
        else $error("table walk out of order");

    // A result beat is produced only from the done state.
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $rose(r_out_valid)) |->
            ($past(r_state) == S_DONE))
        else $error("result beat loaded outside the done state");

endmodule

`default_nettype wire

// File: tb/edge_list_checker.sv
// Scoreboard for the edge list table: watches both channels and the mode register port.
// Predicts every result beat from its own copy of the table and compares it field by field.
// Depends on elt_pkg.
module edge_list_checker
    import elt_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_beat  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_beat i_out_data,
    input  logic      i_cfg_we,
    input  logic      i_cfg_data,
    input  logic      i_wrap_up,
    output int        o_mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    t_vertex   src_tab [TABLE_DEPTH];
    t_vertex   dst_tab [TABLE_DEPTH];
    int        edge_total;
    t_vertex   top_vertex;
    bit        directed;
    t_out_beat pending_results [$];
    t_out_beat want;
    bit        wrapped;

    task automatic report_mismatch(input string msg);
        if (o_mismatches < 100) begin
            $display("ERROR at %0t ns: %s", $realtime, msg);
        end
        o_mismatches++;
    endtask

    function automatic bit edge_hit(input int idx, input t_vertex va, input t_vertex vb);
        return (src_tab[idx] == va && dst_tab[idx] == vb) ||
               (!directed && src_tab[idx] == vb && dst_tab[idx] == va);
    endfunction

    // Applies one request to the local table and returns the result beat it must produce.
    function automatic t_out_beat apply_edge_op(input t_in_beat beat);
        t_out_beat res;
        t_vertex   va;
        t_vertex   vb;
        t_vertex   new_top;
        int        kept;
        bit        bad_pair;
        res = '0;
        va = beat.vertex_a;
        vb = beat.vertex_b;
        bad_pair = va == 0 || vb == 0 || va > top_vertex || vb > top_vertex;
        case (beat.operation)
            OP_ADD: begin
                if (va == 0 || vb == 0) begin
                    res.status = ST_INVALID;
                end else if (edge_total >= TABLE_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    src_tab[edge_total] = va;
                    dst_tab[edge_total] = vb;
                    edge_total++;
                    if (va > top_vertex) top_vertex = va;
                    if (vb > top_vertex) top_vertex = vb;
                end
            end
            OP_REMOVE: begin
                if (bad_pair) begin
                    res.status = ST_INVALID;
                end else begin
                    kept = 0;
                    new_top = '0;
                    for (int i = 0; i < edge_total; i++) begin
                        if (!edge_hit(i, va, vb)) begin
                            src_tab[kept] = src_tab[i];
                            dst_tab[kept] = dst_tab[i];
                            if (src_tab[i] > new_top) new_top = src_tab[i];
                            if (dst_tab[i] > new_top) new_top = dst_tab[i];
                            kept++;
                        end
                    end
                    if (kept == edge_total) begin
                        res.status = ST_NOT_FOUND;
                    end else begin
                        edge_total = kept;
                        top_vertex = new_top;
                    end
                end
            end
            OP_QUERY: begin
                if (bad_pair) begin
                    res.status = ST_INVALID;
                end else begin
                    for (int i = 0; i < edge_total; i++) begin
                        if (edge_hit(i, va, vb)) res.found = 1'b1;
                    end
                end
            end
            default: begin
                // In undirected mode the out-degree is always reported as zero.
                if (directed) begin
                    for (int i = 0; i < edge_total; i++) begin
                        if (src_tab[i] == va) res.degree++;
                    end
                end
            end
        endcase
        res.max_vertex = top_vertex;
        res.edge_count = t_count'(edge_total);
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            edge_total = 0;
            top_vertex = '0;
            directed = 1'b1;
            pending_results.delete();
            o_mismatches = 0;
            wrapped = 1'b0;
        end else begin
            if (i_cfg_we) directed = i_cfg_data;
            if (i_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result beat with no request outstanding");
                end else begin
                    want = pending_results.pop_front();
                    if (i_out_data.status != want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  i_out_data.status, want.status));
                    if (i_out_data.found != want.found)
                        report_mismatch($sformatf("found %0d, expected %0d",
                                                  i_out_data.found, want.found));
                    if (i_out_data.degree != want.degree)
                        report_mismatch($sformatf("degree %0d, expected %0d",
                                                  i_out_data.degree, want.degree));
                    if (i_out_data.max_vertex != want.max_vertex)
                        report_mismatch($sformatf("max_vertex %0d, expected %0d",
                                                  i_out_data.max_vertex, want.max_vertex));
                    if (i_out_data.edge_count != want.edge_count)
                        report_mismatch($sformatf("edge_count %0d, expected %0d",
                                                  i_out_data.edge_count, want.edge_count));
                end
            end
            if (i_in_valid && i_in_ready) pending_results.push_back(apply_edge_op(i_in_data));
            if (i_wrap_up && !wrapped) begin
                wrapped = 1'b1;
                while (pending_results.size() != 0) begin
                    void'(pending_results.pop_front());
                    report_mismatch("expected result beat never arrived");
                end
            end
        end
    end

endmodule

// File: tb/tb_edge_list_table.sv
// Testbench top for the edge list table: clock, reset, request and result traffic, verdict.
// Checking is done by edge_list_checker, instantiated beside the block.
// Depends on elt_pkg, edge_list_table and edge_list_checker.
module tb_edge_list_table;
    timeunit 1ns;
    timeprecision 1ps;

    import elt_pkg::*;

    localparam int MAX_EDGES   = 1024;
    localparam int FILL_EDGES  = 200;
    localparam int CYCLE_LIMIT = 2_000_000;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_beat  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_beat out_data;
    logic      cfg_we    = 1'b0;
    logic      cfg_data  = 1'b0;
    logic      wrap_up   = 1'b0;
    int        mismatches;

    bit steady_flow;
    int items_sent;
    int results_taken;

    edge_list_table #(
        .MAX_EDGES   (MAX_EDGES),
        .VERTEX_BITS (VERTEX_FIELD_W)
    ) u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    edge_list_checker #(
        .TABLE_DEPTH (MAX_EDGES)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .i_wrap_up    (wrap_up),
        .o_mismatches (mismatches)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("Timeout after %0d cycles", CYCLE_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) results_taken++;
    end

    // Result side: random stalls, plus one long hold-off early on so the block backs up.
    initial begin : sink
        int  hold_left;
        bit  held;
        hold_left = 0;
        held = 1'b0;
        forever begin
            @(negedge clk);
            if (!held && results_taken >= 30) begin
                held = 1'b1;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= rst_n && (steady_flow || $urandom_range(99) >= 33);
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic offer_item(input t_op op, input t_vertex va, input t_vertex vb);
        t_in_beat beat;
        beat.operation = op;
        beat.vertex_a = va;
        beat.vertex_b = vb;
        while (!steady_flow && $urandom_range(99) < 33) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= beat;
        do @(posedge clk); while (!(in_valid && in_ready));
        items_sent++;
        @(negedge clk);
    endtask

    // Stops offering and waits until every outstanding result has come back.
    task automatic settle();
        in_valid <= 1'b0;
        while (results_taken != items_sent) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_mode(input bit directed);
        cfg_we <= 1'b1;
        cfg_data <= directed;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Mostly a small set of vertices so edges collide; now and then zero, a wide
    // pattern, or (for lookups) any value at all.
    function automatic t_vertex pick_vertex(input bit any_value);
        t_vertex wide_pool [5];
        int      r;
        wide_pool = '{16'h8000, 16'hFFFF, 16'h7FFF, 16'hAAAA, 16'h5555};
        r = $urandom_range(99);
        if (r < 4) return '0;
        if (r < 8) return wide_pool[$urandom_range(4)];
        if (any_value && r < 18) return t_vertex'($urandom);
        return t_vertex'($urandom_range(10, 1));
    endfunction

    task automatic run_random(input int count);
        int      n;
        int      r;
        t_vertex va;
        t_vertex vb;
        n = 0;
        while (n < count) begin
            r = $urandom_range(99);
            va = pick_vertex(1'b0);
            vb = pick_vertex(1'b0);
            if (r < 20) begin
                // Add an edge, then look it up, count from its source and take it out,
                // sometimes naming it the other way round.
                offer_item(OP_ADD, va, vb);
                if ($urandom_range(1)) offer_item(OP_QUERY, vb, va);
                else offer_item(OP_QUERY, va, vb);
                offer_item(OP_DEGREE, va, t_vertex'($urandom));
                if ($urandom_range(1)) offer_item(OP_REMOVE, vb, va);
                else offer_item(OP_REMOVE, va, vb);
                n += 4;
            end else begin
                if (r < 48) offer_item(OP_ADD, va, vb);
                else if (r < 66) offer_item(OP_REMOVE, pick_vertex(1'b1), pick_vertex(1'b1));
                else if (r < 86) offer_item(OP_QUERY, pick_vertex(1'b1), pick_vertex(1'b1));
                else offer_item(OP_DEGREE, pick_vertex(1'b1), t_vertex'($urandom));
                n++;
            end
        end
    endtask

    initial begin : stimulus
        t_vertex fill_dest [4];
        fill_dest = '{16'd1, 16'h8000, 16'hFFFF, 16'd7};
        steady_flow = 1'b0;
        items_sent = 0;
        results_taken = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        write_mode(1'b1);

        // Empty table, zero vertices, duplicates, misses and removal down to empty.
        offer_item(OP_ADD, 16'd0, 16'd5);
        offer_item(OP_ADD, 16'd5, 16'd0);
        offer_item(OP_QUERY, 16'd1, 16'd2);
        offer_item(OP_REMOVE, 16'd1, 16'd2);
        offer_item(OP_DEGREE, 16'd0, 16'hFFFF);
        offer_item(OP_ADD, 16'd1, 16'd2);
        offer_item(OP_ADD, 16'd1, 16'd2);
        offer_item(OP_ADD, 16'd2, 16'd1);
        offer_item(OP_ADD, 16'hFFFF, 16'h8000);
        offer_item(OP_QUERY, 16'd2, 16'd1);
        offer_item(OP_QUERY, 16'd3, 16'd1);
        offer_item(OP_DEGREE, 16'd1, 16'd0);
        offer_item(OP_DEGREE, 16'h1234, 16'd9);
        offer_item(OP_REMOVE, 16'd3, 16'd4);
        offer_item(OP_REMOVE, 16'hFFFF, 16'h8000);
        offer_item(OP_QUERY, 16'hFFFF, 16'd1);
        offer_item(OP_REMOVE, 16'd1, 16'd2);
        offer_item(OP_REMOVE, 16'd2, 16'd1);
        settle();

        write_mode(1'b0);
        offer_item(OP_ADD, 16'd3, 16'd4);
        offer_item(OP_QUERY, 16'd4, 16'd3);
        offer_item(OP_DEGREE, 16'd3, 16'd4);
        offer_item(OP_REMOVE, 16'd4, 16'd3);
        settle();

        // Load a long run of edges from one source so the walks get long,
        // then take them out again.
        write_mode(1'b1);
        for (int i = 0; i < FILL_EDGES; i++) begin
            offer_item(OP_ADD, 16'hFFFF, fill_dest[i % 4]);
        end
        offer_item(OP_ADD, 16'd2, 16'd3);
        offer_item(OP_ADD, 16'd0, 16'd1);
        offer_item(OP_ADD, 16'hFFFF, 16'd1);
        offer_item(OP_DEGREE, 16'hFFFF, 16'd0);
        offer_item(OP_QUERY, 16'hFFFF, 16'd7);
        offer_item(OP_QUERY, 16'd7, 16'hFFFF);
        for (int i = 0; i < 4; i++) begin
            offer_item(OP_REMOVE, 16'hFFFF, fill_dest[i]);
        end
        settle();

        steady_flow = 1'b1;
        run_random(150);
        settle();
        steady_flow = 1'b0;
        write_mode(1'b0);
        run_random(65);
        settle();
        write_mode(1'b1);
        run_random(65);
        settle();
        write_mode(1'b0);
        run_random(65);
        settle();

        repeat (10) @(negedge clk);
        wrap_up <= 1'b1;
        repeat (2) @(negedge clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
